### src/sst_pkg.sv
// Shared types, widths and codes for the session slot table.
package sst_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;
  localparam int REQ_W      = 3;
  localparam int ST_W       = 3;
  localparam int ADDR_W     = 64;
  localparam int CLI_W      = 32;
  localparam int JOIN_W     = 32;
  localparam int CAP_W      = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd8;

  localparam logic [REQ_W-1:0] REQ_ADMIT     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FIND_ADDR = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIND_CLI  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REBIND    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DROP      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SET_AUDIO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SNAPSHOT  = 3'd7;

  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_FREE     = 3'd2;
  localparam logic [ST_W-1:0] ST_OVER_BUDGET = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO_ADDR   = 3'd4;
  localparam logic [ST_W-1:0] ST_INACTIVE    = 3'd5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CLI_W-1:0]  client_t;
  typedef logic [JOIN_W-1:0] join_ord_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    client_t          client_id;
    addr_t            address;
    slot_t            slot_index;
    logic             flag;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    slot_t           slot_out;
    addr_t           address_out;
    client_t         client_out;
    join_ord_t       join_order_out;
    cnt_t            active_count;
    logic            entry_valid;
    logic            last;
  } rsp_t;

  typedef struct packed {
    logic      wr_entry;
    logic      wr_addr;
    logic      set_active;
    logic      clr_one;
    logic      clr_all;
    logic      set_audio;
    logic      audio_val;
    slot_t     slot;
    addr_t     addr;
    client_t   client;
    join_ord_t join_ord;
  } st_wr_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0] active;
    logic [SLOT_COUNT-1:0] audio;
    addr_t                 addr;
    client_t               client;
    join_ord_t             join_ord;
  } st_rd_t;

endpackage

### src/sst_ifs.sv
// Handshake channel interfaces: request, response and configuration write.
interface sst_req_if;
  logic                        valid;
  logic                        ready;
  logic [sst_pkg::REQ_W-1:0]   req_type;
  logic [sst_pkg::CLI_W-1:0]   client_id;
  logic [sst_pkg::ADDR_W-1:0]  address;
  logic [sst_pkg::SLOT_W-1:0]  slot_index;
  logic                        flag;
  modport source (output valid, req_type, client_id, address, slot_index, flag,
                  input ready);
  modport sink (input valid, req_type, client_id, address, slot_index, flag,
                output ready);
endinterface

interface sst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sst_pkg::ST_W-1:0]    status;
  logic [sst_pkg::SLOT_W-1:0]  slot_out;
  logic [sst_pkg::ADDR_W-1:0]  address_out;
  logic [sst_pkg::CLI_W-1:0]   client_out;
  logic [sst_pkg::JOIN_W-1:0]  join_order_out;
  logic [sst_pkg::CNT_W-1:0]   active_count;
  logic                        entry_valid;
  logic                        last;
  modport source (output valid, status, slot_out, address_out, client_out,
                  join_order_out, active_count, entry_valid, last, input ready);
  modport sink (input valid, status, slot_out, address_out, client_out,
                join_order_out, active_count, entry_valid, last, output ready);
endinterface

interface sst_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sst_pkg::CAP_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/session_slot_table.sv
// Top level of the session slot table.
//
//   channel  dir  word                                           handshake
//   in_ch    in   req_type, client_id, address, slot_index, flag valid/ready
//   out_ch   out  status, slot/address/client/join, count, flags valid/ready
//   cfg_ch   in   max_active (data)                              valid/ready
//
// One request at a time: accept, then the scan pointer visits slots through the
// shared compare unit, and each result word is offered in turn. Index ops read
// only the indexed slot and clear needs no scan; admit and finds visit up to 8;
// snapshot visits up to 8 and returns one word per listed slot.
// Sync active-low reset empties the table and sets max_active to 8.
// A stalled result holds the sequencer; cfg_ch is always ready.
module session_slot_table (
  input  logic       clk,
  input  logic       rst_n,
  sst_req_if.sink    in_ch,
  sst_rsp_if.source  out_ch,
  sst_cfg_if.sink    cfg_ch
);
  import sst_pkg::*;

  st_wr_t wr;
  st_rd_t rd;
  slot_t  rd_slot;
  req_t   cur_req;
  logic   hit;

  sst_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_slot (rd_slot),
    .rd      (rd)
  );

  sst_match u_match (
    .req  (cur_req),
    .rd   (rd),
    .slot (rd_slot),
    .hit  (hit)
  );

  sst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .hit     (hit),
    .rd      (rd),
    .rd_slot (rd_slot),
    .cur_req (cur_req),
    .wr      (wr)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("request accepted while a result word is pending");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.active_count <= CNT_W'(SLOT_COUNT))
    else $error("active count beyond slot count");

  a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |->
      (out_ch.last && out_ch.slot_out == '0 && out_ch.address_out == '0 &&
       out_ch.entry_valid == 1'b0))
    else $error("failed request word carries slot data");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.entry_valid) |->
      (out_ch.status == ST_OK && out_ch.join_order_out == '0))
    else $error("snapshot entry with bad status or join order");

endmodule

### src/sst_store.sv
// Slot storage: active and audio bits in flops, entry fields read at one slot.
module sst_store (
  input  logic            clk,
  input  logic            rst_n,
  input  sst_pkg::st_wr_t wr,
  input  sst_pkg::slot_t  rd_slot,
  output sst_pkg::st_rd_t rd
);
  import sst_pkg::*;

  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [SLOT_COUNT-1:0] audio_r, audio_nxt;
  addr_t                 addr_r [SLOT_COUNT];
  client_t               client_r [SLOT_COUNT];
  join_ord_t             join_r [SLOT_COUNT];

  always_comb begin
    active_nxt = active_r;
    audio_nxt  = audio_r;
    if (wr.clr_all) begin
      active_nxt = '0;
      audio_nxt  = '0;
    end else if (wr.set_active) begin
      active_nxt[wr.slot] = 1'b1;
      audio_nxt[wr.slot]  = 1'b0;
    end else if (wr.clr_one) begin
      active_nxt[wr.slot] = 1'b0;
      audio_nxt[wr.slot]  = 1'b0;
    end else if (wr.set_audio) begin
      audio_nxt[wr.slot] = wr.audio_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      audio_r  <= '0;
    end else begin
      active_r <= active_nxt;
      audio_r  <= audio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_entry) begin
      addr_r[wr.slot]   <= wr.addr;
      client_r[wr.slot] <= wr.client;
      join_r[wr.slot]   <= wr.join_ord;
    end else if (wr.wr_addr) begin
      addr_r[wr.slot] <= wr.addr;
    end
  end

  assign rd.active   = active_r;
  assign rd.audio    = audio_r;
  assign rd.addr     = addr_r[rd_slot];
  assign rd.client   = client_r[rd_slot];
  assign rd.join_ord = join_r[rd_slot];

endmodule

### src/sst_match.sv
// Shared slot compare unit: one equality compare plus per-request hit rule.
module sst_match (
  input  sst_pkg::req_t   req,
  input  sst_pkg::st_rd_t rd,
  input  sst_pkg::slot_t  slot,
  output logic            hit
);
  import sst_pkg::*;

  addr_t lhs, rhs;
  logic  eq, act, aud;

  assign act = rd.active[slot];
  assign aud = rd.audio[slot];
  assign lhs = (req.req_type == REQ_FIND_CLI) ? {{(ADDR_W-CLI_W){1'b0}}, rd.client} : rd.addr;
  assign rhs = (req.req_type == REQ_FIND_CLI) ? {{(ADDR_W-CLI_W){1'b0}}, req.client_id}
                                              : req.address;
  assign eq  = (lhs == rhs);

  always_comb begin
    unique case (req.req_type)
      REQ_ADMIT:     hit = !act;
      REQ_FIND_ADDR: hit = act && eq;
      REQ_FIND_CLI:  hit = act && eq;
      REQ_SNAPSHOT:  hit = act && (!req.flag || aud);
      default:       hit = 1'b0;
    endcase
  end

endmodule

### src/sst_ctrl.sv
// Request sequencer: slot scan pointer, counters, budget register, result word.
module sst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  sst_req_if.sink          in_ch,
  sst_rsp_if.source        out_ch,
  sst_cfg_if.sink          cfg_ch,
  input  logic             hit,
  input  sst_pkg::st_rd_t  rd,
  output sst_pkg::slot_t   rd_slot,
  output sst_pkg::req_t    cur_req,
  output sst_pkg::st_wr_t  wr
);
  import sst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  req_t             req_r, req_nxt;
  slot_t            ptr_r, ptr_nxt;
  cnt_t             count_r, count_nxt;
  join_ord_t        join_cnt_r, join_cnt_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  rsp_t             rsp_r, rsp_nxt;

  logic [SLOT_COUNT-1:0] snap_m, later_m;
  logic                  idx_act, scan_end, addr_zero, at_cap;
  rsp_t                  base;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign rd_slot      = ptr_r;
  assign cur_req      = req_r;

  assign out_ch.valid          = (state_r == S_OUT);
  assign out_ch.status         = rsp_r.status;
  assign out_ch.slot_out       = rsp_r.slot_out;
  assign out_ch.address_out    = rsp_r.address_out;
  assign out_ch.client_out     = rsp_r.client_out;
  assign out_ch.join_order_out = rsp_r.join_order_out;
  assign out_ch.active_count   = rsp_r.active_count;
  assign out_ch.entry_valid    = rsp_r.entry_valid;
  assign out_ch.last           = rsp_r.last;

  assign snap_m    = rd.active & (req_r.flag ? rd.audio : '1);
  assign idx_act   = rd.active[ptr_r];
  assign scan_end  = (ptr_r == slot_t'(SLOT_COUNT - 1));
  assign addr_zero = (req_r.address == '0);
  assign at_cap    = ({{(CAP_W-CNT_W){1'b0}}, count_r} >= cap_r);

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      later_m[i] = snap_m[i] && (slot_t'(i) > ptr_r);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    ptr_nxt      = ptr_r;
    count_nxt    = count_r;
    join_cnt_nxt = join_cnt_r;
    cap_nxt      = cap_r;
    rsp_nxt      = rsp_r;

    wr          = '0;
    wr.slot     = ptr_r;
    wr.addr     = req_r.address;
    wr.client   = req_r.client_id;
    wr.join_ord = join_cnt_r;
    wr.audio_val = req_r.flag;

    base              = '0;
    base.active_count = count_r;
    base.last         = 1'b1;

    if (cfg_ch.valid) begin
      cap_nxt = cfg_ch.data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt.req_type   = in_ch.req_type;
          req_nxt.client_id  = in_ch.client_id;
          req_nxt.address    = in_ch.address;
          req_nxt.slot_index = in_ch.slot_index;
          req_nxt.flag       = in_ch.flag;
          if (in_ch.req_type == REQ_REBIND || in_ch.req_type == REQ_DROP ||
              in_ch.req_type == REQ_SET_AUDIO) begin
            ptr_nxt = in_ch.slot_index;
          end else begin
            ptr_nxt = '0;
          end
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_OUT;
        rsp_nxt   = base;
        unique case (req_r.req_type)
          REQ_ADMIT: begin
            if (addr_zero) begin
              rsp_nxt.status = ST_ZERO_ADDR;
            end else if (hit) begin
              if (at_cap) begin
                rsp_nxt.status = ST_OVER_BUDGET;
              end else begin
                wr.set_active  = 1'b1;
                wr.wr_entry    = 1'b1;
                join_cnt_nxt   = join_cnt_r + join_ord_t'(1);
                count_nxt      = count_r + cnt_t'(1);
                rsp_nxt.slot_out       = ptr_r;
                rsp_nxt.address_out    = req_r.address;
                rsp_nxt.client_out     = req_r.client_id;
                rsp_nxt.join_order_out = join_cnt_r;
                rsp_nxt.active_count   = count_r + cnt_t'(1);
              end
            end else if (scan_end) begin
              rsp_nxt.status = ST_NO_FREE;
            end else begin
              ptr_nxt   = ptr_r + slot_t'(1);
              state_nxt = S_EXEC;
              rsp_nxt   = rsp_r;
            end
          end
          REQ_FIND_ADDR, REQ_FIND_CLI: begin
            if (req_r.req_type == REQ_FIND_ADDR && addr_zero) begin
              rsp_nxt.status = ST_ZERO_ADDR;
            end else if (hit) begin
              rsp_nxt.slot_out       = ptr_r;
              rsp_nxt.address_out    = rd.addr;
              rsp_nxt.client_out     = rd.client;
              rsp_nxt.join_order_out = rd.join_ord;
            end else if (scan_end) begin
              rsp_nxt.status = ST_NOT_FOUND;
            end else begin
              ptr_nxt   = ptr_r + slot_t'(1);
              state_nxt = S_EXEC;
              rsp_nxt   = rsp_r;
            end
          end
          REQ_REBIND: begin
            if (!idx_act) begin
              rsp_nxt.status = ST_INACTIVE;
            end else if (addr_zero) begin
              rsp_nxt.status = ST_ZERO_ADDR;
            end else begin
              wr.wr_addr             = 1'b1;
              rsp_nxt.slot_out       = ptr_r;
              rsp_nxt.address_out    = req_r.address;
              rsp_nxt.client_out     = rd.client;
              rsp_nxt.join_order_out = rd.join_ord;
            end
          end
          REQ_DROP: begin
            if (!idx_act) begin
              rsp_nxt.status = ST_INACTIVE;
            end else begin
              wr.clr_one           = 1'b1;
              count_nxt            = count_r - cnt_t'(1);
              rsp_nxt.slot_out     = ptr_r;
              rsp_nxt.active_count = count_r - cnt_t'(1);
            end
          end
          REQ_CLEAR: begin
            wr.clr_all           = 1'b1;
            count_nxt            = '0;
            rsp_nxt.active_count = '0;
          end
          REQ_SET_AUDIO: begin
            if (!idx_act) begin
              rsp_nxt.status = ST_INACTIVE;
            end else begin
              wr.set_audio           = 1'b1;
              rsp_nxt.slot_out       = ptr_r;
              rsp_nxt.address_out    = rd.addr;
              rsp_nxt.client_out     = rd.client;
              rsp_nxt.join_order_out = rd.join_ord;
            end
          end
          REQ_SNAPSHOT: begin
            if (snap_m == '0) begin
              rsp_nxt = base;
            end else if (hit) begin
              rsp_nxt.slot_out    = ptr_r;
              rsp_nxt.address_out = rd.addr;
              rsp_nxt.client_out  = rd.client;
              rsp_nxt.entry_valid = 1'b1;
              rsp_nxt.last        = (later_m == '0);
            end else begin
              ptr_nxt   = ptr_r + slot_t'(1);
              state_nxt = S_EXEC;
              rsp_nxt   = rsp_r;
            end
          end
        endcase
      end

      S_OUT: begin
        if (out_ch.ready) begin
          if (rsp_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + slot_t'(1);
            state_nxt = S_EXEC;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      join_cnt_r <= '0;
      cap_r      <= CAP_RESET;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      join_cnt_r <= join_cnt_nxt;
      cap_r      <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    ptr_r <= ptr_nxt;
    rsp_r <= rsp_nxt;
  end

endmodule

### tb/session_slot_table_tb.sv
// Self-checking testbench for the session slot table: directed table, then random phases.
module session_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t rsp;
  } stim_row_t;

  localparam addr_t ONES64 = '1;
  localparam client_t ONES32 = '1;

  localparam int DIR_ROWS = 28;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{REQ_SNAPSHOT, 32'd0, 64'd0, 3'd0, 1'b0}, 1'b1,
      '{ST_OK, 3'd0, 64'd0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b1}},
    '{'{REQ_FIND_ADDR, 32'd7, 64'd0, 3'd0, 1'b0}, 1'b1,
      '{ST_ZERO_ADDR, 3'd0, 64'd0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b1}},
    '{'{REQ_ADMIT, 32'd5, 64'd0, 3'd0, 1'b0}, 1'b1,
      '{ST_ZERO_ADDR, 3'd0, 64'd0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b1}},
    '{'{REQ_ADMIT, ONES32, ONES64, 3'd7, 1'b1}, 1'b1,
      '{ST_OK, 3'd0, ONES64, ONES32, 32'd0, 4'd1, 1'b0, 1'b1}},
    '{'{REQ_ADMIT, 32'd0, 64'd1, 3'd0, 1'b0}, 1'b1,
      '{ST_OK, 3'd1, 64'd1, 32'd0, 32'd1, 4'd2, 1'b0, 1'b1}},
    '{'{REQ_FIND_ADDR, 32'd0, ONES64, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_FIND_ADDR, 32'd0, 64'd2, 3'd0, 1'b0}, 1'b1,
      '{ST_NOT_FOUND, 3'd0, 64'd0, 32'd0, 32'd0, 4'd2, 1'b0, 1'b1}},
    '{'{REQ_REBIND, 32'd0, 64'd3, 3'd7, 1'b0}, 1'b1,
      '{ST_INACTIVE, 3'd0, 64'd0, 32'd0, 32'd0, 4'd2, 1'b0, 1'b1}},
    '{'{REQ_REBIND, 32'd0, 64'd0, 3'd1, 1'b0}, 1'b1,
      '{ST_ZERO_ADDR, 3'd0, 64'd0, 32'd0, 32'd0, 4'd2, 1'b0, 1'b1}},
    '{'{REQ_REBIND, 32'd0, 64'hA5A5_A5A5_5A5A_5A5A, 3'd1, 1'b0}, 1'b0, '0},
    '{'{REQ_REBIND, 32'd0, 64'hA5A5_A5A5_5A5A_5A5A, 3'd1, 1'b1}, 1'b0, '0},
    '{'{REQ_SET_AUDIO, 32'd0, 64'd0, 3'd0, 1'b1}, 1'b0, '0},
    '{'{REQ_SNAPSHOT, 32'd0, 64'd0, 3'd0, 1'b1}, 1'b0, '0},
    '{'{REQ_SNAPSHOT, 32'd0, 64'd0, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_DROP, 32'd0, 64'd0, 3'd6, 1'b0}, 1'b1,
      '{ST_INACTIVE, 3'd0, 64'd0, 32'd0, 32'd0, 4'd2, 1'b0, 1'b1}},
    '{'{REQ_DROP, 32'd0, 64'd0, 3'd0, 1'b0}, 1'b1,
      '{ST_OK, 3'd0, 64'd0, 32'd0, 32'd0, 4'd1, 1'b0, 1'b1}},
    '{'{REQ_SET_AUDIO, 32'd0, 64'd0, 3'd0, 1'b1}, 1'b1,
      '{ST_INACTIVE, 3'd0, 64'd0, 32'd0, 32'd0, 4'd1, 1'b0, 1'b1}},
    '{'{REQ_ADMIT, 32'h0000_0010, 64'h10, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_ADMIT, 32'h0000_0011, 64'h11, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_ADMIT, 32'h0000_0012, 64'h12, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_ADMIT, 32'h8000_0013, 64'h8000_0000_0000_0013, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_ADMIT, 32'h0000_0014, 64'h14, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_ADMIT, 32'h0000_0015, 64'h15, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_ADMIT, 32'h0000_0016, 64'h16, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_ADMIT, 32'h0000_0020, 64'h20, 3'd0, 1'b0}, 1'b1,
      '{ST_NO_FREE, 3'd0, 64'd0, 32'd0, 32'd0, 4'd8, 1'b0, 1'b1}},
    '{'{REQ_SNAPSHOT, 32'd0, 64'd0, 3'd0, 1'b0}, 1'b0, '0},
    '{'{REQ_CLEAR, 32'd0, 64'd0, 3'd0, 1'b0}, 1'b1,
      '{ST_OK, 3'd0, 64'd0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b1}},
    '{'{REQ_ADMIT, 32'h1234_5678, 64'h30, 3'd0, 1'b0}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  sst_req_if req_if ();
  sst_rsp_if rsp_if ();
  sst_cfg_if cfg_if ();

  session_slot_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if.sink),
    .out_ch (rsp_if.source),
    .cfg_ch (cfg_if.sink)
  );

  always #4 clk = ~clk;

  // table predictor state
  bit        tbl_active [SLOT_COUNT];
  client_t   tbl_client [SLOT_COUNT];
  addr_t     tbl_addr   [SLOT_COUNT];
  join_ord_t tbl_join   [SLOT_COUNT];
  bit        tbl_audio  [SLOT_COUNT];
  join_ord_t tbl_next_join;
  int        tbl_count;
  logic [CAP_W-1:0] tbl_cap;

  rsp_t    due_words [$];
  addr_t   addr_pool [8];
  client_t cli_pool  [4];

  bit idle_on;
  int errors;
  int words_seen;
  int reqs_sent;
  int cycles;

  function automatic rsp_t mk_word(logic [ST_W-1:0] st, slot_t s, addr_t a, client_t c,
                                   join_ord_t j, logic ev, logic lst);
    rsp_t w;
    w.status         = st;
    w.slot_out       = s;
    w.address_out    = a;
    w.client_out     = c;
    w.join_order_out = j;
    w.active_count   = cnt_t'(tbl_count);
    w.entry_valid    = ev;
    w.last           = lst;
    return w;
  endfunction

  function automatic rsp_t slot_word(int i);
    return mk_word(ST_OK, slot_t'(i), tbl_addr[i], tbl_client[i], tbl_join[i], 1'b0, 1'b1);
  endfunction

  function automatic rsp_t fail_word(logic [ST_W-1:0] st);
    return mk_word(st, '0, '0, '0, '0, 1'b0, 1'b1);
  endfunction

  function automatic void empty_slot(int i);
    tbl_active[i] = 1'b0;
    tbl_client[i] = '0;
    tbl_addr[i]   = '0;
    tbl_join[i]   = '0;
    tbl_audio[i]  = 1'b0;
  endfunction

  function automatic int predict_table_words(input req_t r, output rsp_t w [SLOT_COUNT]);
    int n;
    int hit;
    int idx;
    n   = 1;
    hit = -1;
    idx = int'(r.slot_index);
    case (r.req_type)
      REQ_ADMIT: begin
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
          if (!tbl_active[i]) hit = i;
        if (r.address == '0) w[0] = fail_word(ST_ZERO_ADDR);
        else if (hit < 0) w[0] = fail_word(ST_NO_FREE);
        else if (tbl_count >= int'(tbl_cap)) w[0] = fail_word(ST_OVER_BUDGET);
        else begin
          tbl_active[hit] = 1'b1;
          tbl_client[hit] = r.client_id;
          tbl_addr[hit]   = r.address;
          tbl_join[hit]   = tbl_next_join;
          tbl_audio[hit]  = 1'b0;
          tbl_next_join   = tbl_next_join + 1;
          tbl_count++;
          w[0] = slot_word(hit);
        end
      end
      REQ_FIND_ADDR, REQ_FIND_CLI: begin
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
          if (tbl_active[i] && ((r.req_type == REQ_FIND_ADDR) ? tbl_addr[i] == r.address
                                                               : tbl_client[i] == r.client_id))
            hit = i;
        if (r.req_type == REQ_FIND_ADDR && r.address == '0) w[0] = fail_word(ST_ZERO_ADDR);
        else if (hit < 0) w[0] = fail_word(ST_NOT_FOUND);
        else w[0] = slot_word(hit);
      end
      REQ_REBIND: begin
        if (!tbl_active[idx]) w[0] = fail_word(ST_INACTIVE);
        else if (r.address == '0) w[0] = fail_word(ST_ZERO_ADDR);
        else begin
          tbl_addr[idx] = r.address;
          w[0] = slot_word(idx);
        end
      end
      REQ_DROP: begin
        if (!tbl_active[idx]) w[0] = fail_word(ST_INACTIVE);
        else begin
          empty_slot(idx);
          tbl_count--;
          w[0] = mk_word(ST_OK, r.slot_index, '0, '0, '0, 1'b0, 1'b1);
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) empty_slot(i);
        tbl_count = 0;
        w[0] = fail_word(ST_OK);
      end
      REQ_SET_AUDIO: begin
        if (!tbl_active[idx]) w[0] = fail_word(ST_INACTIVE);
        else begin
          tbl_audio[idx] = r.flag;
          w[0] = slot_word(idx);
        end
      end
      default: begin
        n = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (tbl_active[i] && !(r.flag && !tbl_audio[i])) begin
            w[n] = mk_word(ST_OK, slot_t'(i), tbl_addr[i], tbl_client[i], '0, 1'b1, 1'b0);
            n++;
          end
        end
        if (n == 0) begin
          w[0] = fail_word(ST_OK);
          n = 1;
        end else begin
          w[n-1].last = 1'b1;
        end
      end
    endcase
    return n;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      r.req_type = REQ_ADMIT;
    else if (pick < 42) r.req_type = REQ_FIND_ADDR;
    else if (pick < 54) r.req_type = REQ_FIND_CLI;
    else if (pick < 64) r.req_type = REQ_REBIND;
    else if (pick < 77) r.req_type = REQ_DROP;
    else if (pick < 80) r.req_type = REQ_CLEAR;
    else if (pick < 90) r.req_type = REQ_SET_AUDIO;
    else                r.req_type = REQ_SNAPSHOT;
    r.client_id = $urandom_range(0, 1) ? cli_pool[$urandom_range(0, 3)] : client_t'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0)     r.address = '0;
    else if (pick < 6) r.address = addr_pool[$urandom_range(0, 7)];
    else               r.address = {$urandom, $urandom};
    r.slot_index = slot_t'($urandom_range(0, SLOT_COUNT - 1));
    r.flag       = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic send_req(input req_t r, input logic typed, input rsp_t typed_word);
    rsp_t w [SLOT_COUNT];
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= r.req_type;
    req_if.client_id  <= r.client_id;
    req_if.address    <= r.address;
    req_if.slot_index <= r.slot_index;
    req_if.flag       <= r.flag;
    do @(posedge clk); while (!req_if.ready);
    n = predict_table_words(r, w);
    if (typed) due_words.push_back(typed_word);
    else for (int i = 0; i < n; i++) due_words.push_back(w[i]);
    reqs_sent++;
  endtask

  task automatic drain_words();
    req_if.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] cap);
    drain_words();
    repeat (4) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tbl_cap = cap;
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      words_seen++;
      if (due_words.size() == 0) begin
        $error("unexpected result word: status %0h slot %0h", rsp_if.status, rsp_if.slot_out);
        errors++;
      end else begin
        e = due_words.pop_front();
        check_field("status", 64'(e.status), 64'(rsp_if.status));
        check_field("slot_out", 64'(e.slot_out), 64'(rsp_if.slot_out));
        check_field("address_out", e.address_out, rsp_if.address_out);
        check_field("client_out", 64'(e.client_out), 64'(rsp_if.client_out));
        check_field("join_order_out", 64'(e.join_order_out), 64'(rsp_if.join_order_out));
        check_field("active_count", 64'(e.active_count), 64'(rsp_if.active_count));
        check_field("entry_valid", 64'(e.entry_valid), 64'(rsp_if.entry_valid));
        check_field("last", 64'(e.last), 64'(rsp_if.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, due_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result-side backpressure
  initial begin
    int hold;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!idle_on) begin
        rsp_if.ready <= 1'b1;
      end else if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) hold = $urandom_range(1, 11);
      end
    end
  end

  initial begin
    logic [CAP_W-1:0] caps [6];
    errors     = 0;
    words_seen = 0;
    reqs_sent  = 0;
    cycles     = 0;
    idle_on    = 1'b1;
    for (int i = 0; i < SLOT_COUNT; i++) empty_slot(i);
    tbl_next_join = '0;
    tbl_count     = 0;
    tbl_cap       = CAP_RESET;
    addr_pool[0] = '1;
    addr_pool[1] = 64'd1;
    for (int i = 2; i < 8; i++) addr_pool[i] = {$urandom, $urandom};
    cli_pool[0] = '1;
    cli_pool[1] = '0;
    cli_pool[2] = $urandom;
    cli_pool[3] = $urandom;
    caps = '{8'd255, 8'd0, 8'd3, 8'd1, 8'($urandom_range(2, 7)), 8'd8};

    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_ADMIT;
    req_if.client_id  <= '0;
    req_if.address    <= '0;
    req_if.slot_index <= '0;
    req_if.flag       <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.data       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_req(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].rsp);

    for (int p = 0; p < 6; p++) begin
      write_cap(caps[p]);
      if (p == 5) idle_on = 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 24) == 0) drain_words();
        send_req(random_request(), 1'b0, '0);
      end
    end

    drain_words();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d result words over budget caps 8, 255, 0, 3, 1, %0d, 8.",
             reqs_sent, words_seen, caps[4]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/sst_pkg.sv
src/sst_ifs.sv
src/sst_store.sv
src/sst_match.sv
src/sst_ctrl.sv
src/session_slot_table.sv
tb/session_slot_table_tb.sv
